>>> design/hfhp_pkg.sv
// ---------------------------------------------------------------------------
// hfhp_pkg: shared types and constants of the hdlc frame header parser
// Field widths, header constants, result kinds and the result record.
// ---------------------------------------------------------------------------
package hfhp_pkg;

  // field widths
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 11;
  localparam int ADDR_W     = 28;
  localparam int HDR_CNT_W  = 4;

  // address bytes: seven value bits each, ends at the byte with bit 0 set
  localparam int MAX_ADDR_BYTES = 4;
  localparam int ADDR_CNT_W     = $clog2(MAX_ADDR_BYTES + 1);
  localparam int ADDR_END_BIT   = 0;

  // stream constants
  localparam logic [BYTE_W-1:0] FLAG_BYTE       = 8'h7E;
  localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 11'h7FF;
  localparam int                FCS_BYTES       = 2;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_LEN_ERR  = 2'd2,
    KIND_ADDR_ERR = 2'd3
  } kind_e;

  // one result record
  typedef struct packed {
    kind_e              kind;
    logic [BYTE_W-1:0]  data_byte;
    logic               last;
    logic [ADDR_W-1:0]  dest_addr;
    logic [ADDR_W-1:0]  src_addr;
    logic [BYTE_W-1:0]  control;
  } res_t;

endpackage

>>> design/hfhp_byte_if.sv
// ---------------------------------------------------------------------------
// hfhp_byte_if: received byte channel
// Carries one raw byte of the hdlc stream per request.
// ---------------------------------------------------------------------------
interface hfhp_byte_if import hfhp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> design/hfhp_res_if.sv
// ---------------------------------------------------------------------------
// hfhp_res_if: parser result channel
// Carries one payload byte, empty-frame marker or error per request.
// ---------------------------------------------------------------------------
interface hfhp_res_if import hfhp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [BYTE_W-1:0] data_byte;
  logic              last;
  logic [ADDR_W-1:0] dest_addr;
  logic [ADDR_W-1:0] src_addr;
  logic [BYTE_W-1:0] control;

  modport source (output valid, output kind, output data_byte, output last,
                  output dest_addr, output src_addr, output control, input ready);
  modport sink   (input valid, input kind, input data_byte, input last,
                  input dest_addr, input src_addr, input control, output ready);
endinterface

>>> design/hfhp_cfg_if.sv
// ---------------------------------------------------------------------------
// hfhp_cfg_if: configuration write channel
// Carries the write data of the max_payload register.
// ---------------------------------------------------------------------------
interface hfhp_cfg_if import hfhp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] max_payload;

  modport source (output valid, output max_payload, input ready);
  modport sink   (input valid, input max_payload, output ready);
endinterface

>>> design/hfhp_core.sv
// ---------------------------------------------------------------------------
// hfhp_core: header state machine and result register
// Takes one registered byte per step, walks the frame header and hands out
// payload bytes, empty-frame markers and errors through a result register.
// ---------------------------------------------------------------------------
module hfhp_core import hfhp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  logic [LEN_W-1:0]  max_payload_i,
  output logic              step_ready_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output res_t              res_o
);

  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_FMT_HI  = 4'd1,
    PH_FMT_LO  = 4'd2,
    PH_DEST    = 4'd3,
    PH_SRC     = 4'd4,
    PH_CTRL    = 4'd5,
    PH_HCS_A   = 4'd6,
    PH_HCS_B   = 4'd7,
    PH_PAYLOAD = 4'd8
  } phase_e;

  localparam int PLEN_W = LEN_W + 2;

  phase_e                phase_q, phase_d;
  logic [LEN_W-1:0]      frame_len_q, frame_len_d;
  logic [ADDR_W-1:0]     dest_q, dest_d;
  logic [ADDR_W-1:0]     src_q, src_d;
  logic [ADDR_CNT_W-1:0] addr_cnt_q, addr_cnt_d;
  logic [HDR_CNT_W-1:0]  hdr_cnt_q, hdr_cnt_d;
  logic [BYTE_W-1:0]     ctrl_q, ctrl_d;
  logic [LEN_W-1:0]      pay_left_q, pay_left_d;
  logic                  res_valid_q, res_valid_d;
  res_t                  res_q, res_d;

  logic                  take;
  logic [ADDR_CNT_W-1:0] addr_cnt_inc;
  logic [HDR_CNT_W-1:0]  hdr_cnt_inc;
  logic                  addr_end;
  logic                  addr_too_long;
  logic [ADDR_W-1:0]     dest_shift;
  logic [ADDR_W-1:0]     src_shift;
  logic [PLEN_W-1:0]     plen;
  logic                  plen_neg;
  logic                  plen_big;

  // the result register frees up when its request is taken
  assign step_ready_o = !res_valid_q || res_ready_i;
  assign take         = step_i && step_ready_o;

  // address byte helpers
  assign addr_cnt_inc  = addr_cnt_q + ADDR_CNT_W'(1);
  assign hdr_cnt_inc   = hdr_cnt_q + HDR_CNT_W'(1);
  assign addr_end      = byte_i[ADDR_END_BIT];
  assign addr_too_long = !addr_end && (addr_cnt_inc >= ADDR_CNT_W'(MAX_ADDR_BYTES));
  assign dest_shift    = {dest_q[ADDR_W-8:0], byte_i[BYTE_W-1:1]};
  assign src_shift     = {src_q[ADDR_W-8:0], byte_i[BYTE_W-1:1]};

  // payload length: frame length less header and fcs bytes
  assign plen     = PLEN_W'(frame_len_q) - PLEN_W'(hdr_cnt_inc) - PLEN_W'(FCS_BYTES);
  assign plen_neg = plen[PLEN_W-1];
  assign plen_big = plen[LEN_W:0] > {1'b0, max_payload_i};

  // next state and result
  always_comb begin
    phase_d     = phase_q;
    frame_len_d = frame_len_q;
    dest_d      = dest_q;
    src_d       = src_q;
    addr_cnt_d  = addr_cnt_q;
    hdr_cnt_d   = hdr_cnt_q;
    ctrl_d      = ctrl_q;
    pay_left_d  = pay_left_q;
    res_valid_d = res_valid_q && !res_ready_i;
    res_d       = res_q;
    if (take) begin
      res_d.kind      = KIND_DATA;
      res_d.data_byte = '0;
      res_d.last      = 1'b1;
      res_d.dest_addr = dest_q;
      res_d.src_addr  = src_q;
      res_d.control   = ctrl_q;
      case (phase_q)
        PH_HUNT: begin
          if (byte_i == FLAG_BYTE) begin
            frame_len_d = '0;
            dest_d      = '0;
            src_d       = '0;
            addr_cnt_d  = '0;
            hdr_cnt_d   = '0;
            ctrl_d      = '0;
            pay_left_d  = '0;
            phase_d     = PH_FMT_HI;
          end
        end
        PH_FMT_HI: begin
          if (byte_i != FLAG_BYTE) begin
            frame_len_d = {byte_i[LEN_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
            hdr_cnt_d   = HDR_CNT_W'(1);
            phase_d     = PH_FMT_LO;
          end
        end
        PH_FMT_LO: begin
          frame_len_d = {frame_len_q[LEN_W-1:BYTE_W], byte_i};
          hdr_cnt_d   = HDR_CNT_W'(2);
          addr_cnt_d  = '0;
          phase_d     = PH_DEST;
        end
        PH_DEST: begin
          dest_d     = dest_shift;
          addr_cnt_d = addr_cnt_inc;
          hdr_cnt_d  = hdr_cnt_inc;
          if (addr_end) begin
            addr_cnt_d = '0;
            phase_d    = PH_SRC;
          end else if (addr_too_long) begin
            phase_d         = PH_HUNT;
            res_valid_d     = 1'b1;
            res_d.kind      = KIND_ADDR_ERR;
            res_d.dest_addr = dest_shift;
          end
        end
        PH_SRC: begin
          src_d      = src_shift;
          addr_cnt_d = addr_cnt_inc;
          hdr_cnt_d  = hdr_cnt_inc;
          if (addr_end) begin
            phase_d = PH_CTRL;
          end else if (addr_too_long) begin
            phase_d        = PH_HUNT;
            res_valid_d    = 1'b1;
            res_d.kind     = KIND_ADDR_ERR;
            res_d.src_addr = src_shift;
          end
        end
        PH_CTRL: begin
          ctrl_d    = byte_i;
          hdr_cnt_d = hdr_cnt_inc;
          phase_d   = PH_HCS_A;
        end
        PH_HCS_A: begin
          hdr_cnt_d = hdr_cnt_inc;
          phase_d   = PH_HCS_B;
        end
        PH_HCS_B: begin
          hdr_cnt_d = hdr_cnt_inc;
          phase_d   = PH_HUNT;
          if (plen_neg || plen_big) begin
            res_valid_d = 1'b1;
            res_d.kind  = KIND_LEN_ERR;
          end else if (plen == '0) begin
            res_valid_d = 1'b1;
            res_d.kind  = KIND_EMPTY;
          end else begin
            pay_left_d = plen[LEN_W-1:0];
            phase_d    = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          res_valid_d     = 1'b1;
          res_d.data_byte = byte_i;
          if (pay_left_q <= LEN_W'(1)) begin
            pay_left_d = '0;
            phase_d    = PH_HUNT;
          end else begin
            pay_left_d = pay_left_q - LEN_W'(1);
            res_d.last = 1'b0;
          end
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  // state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      frame_len_q <= '0;
      dest_q      <= '0;
      src_q       <= '0;
      addr_cnt_q  <= '0;
      hdr_cnt_q   <= '0;
      ctrl_q      <= '0;
      pay_left_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      frame_len_q <= frame_len_d;
      dest_q      <= dest_d;
      src_q       <= src_d;
      addr_cnt_q  <= addr_cnt_d;
      hdr_cnt_q   <= hdr_cnt_d;
      ctrl_q      <= ctrl_d;
      pay_left_q  <= pay_left_d;
      res_valid_q <= res_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // checks
  a_nondata_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.kind != KIND_DATA) |-> res_o.last)
    else $error("non-data result without last");

  a_nondata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.kind != KIND_DATA) |-> (res_o.data_byte == '0))
    else $error("non-data result with data byte");

  a_new_res_from_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !$past(res_valid_o) |-> $past(take))
    else $error("result appeared without a step");

  a_addr_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    addr_cnt_q <= ADDR_CNT_W'(MAX_ADDR_BYTES))
    else $error("address byte count out of range");

  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (pay_left_q != '0))
    else $error("payload phase with nothing left");

endmodule

>>> design/hdlc_frame_header_parser.sv
// ---------------------------------------------------------------------------
// hdlc_frame_header_parser: top level of the hdlc frame header parser
// Input byte register, max_payload register and the header state machine.
// ---------------------------------------------------------------------------
// The parser takes one byte per clock and gives at most one result per byte.
// A byte goes into an input register, is handled by the header state machine
// and its result, if any, sits in a result register, so a result appears in
// the cycle after the core takes its byte. With the result side ready the
// block sustains one byte per cycle; a stalled result register holds the
// input register, which buffers one byte, and rx ready drops while it is
// full. No clearing pass follows reset. max_payload may be written at
// any time the parser is idle; its write channel is always ready.
module hdlc_frame_header_parser import hfhp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  hfhp_byte_if.sink  rx_i,
  hfhp_cfg_if.sink   cfg_i,
  hfhp_res_if.source res_o
);

  logic              in_valid_q, in_valid_d;
  logic [BYTE_W-1:0] in_byte_q;
  logic [LEN_W-1:0]  max_payload_q;
  logic              step_ready;
  logic              rx_take;
  res_t              res;

  // input register accepts when empty or draining into the core
  assign rx_i.ready = !in_valid_q || step_ready;
  assign rx_take    = rx_i.valid && rx_i.ready;
  assign in_valid_d = rx_take || (in_valid_q && !step_ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_take) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  // max_payload register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MAX_PAYLOAD_RST;
    end else if (cfg_i.valid) begin
      max_payload_q <= cfg_i.max_payload;
    end
  end

  // header state machine and result register
  hfhp_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (in_valid_q),
    .byte_i        (in_byte_q),
    .max_payload_i (max_payload_q),
    .step_ready_o  (step_ready),
    .res_valid_o   (res_o.valid),
    .res_ready_i   (res_o.ready),
    .res_o         (res)
  );

  // result channel
  assign res_o.kind      = res.kind;
  assign res_o.data_byte = res.data_byte;
  assign res_o.last      = res.last;
  assign res_o.dest_addr = res.dest_addr;
  assign res_o.src_addr  = res.src_addr;
  assign res_o.control   = res.control;

  // a held byte stays put until the core takes it
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step_ready |=> in_valid_q && $stable(in_byte_q))
    else $error("input byte lost while core stalled");

endmodule
